// ===== design/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat send window
// Command codes, result codes, the queued request and the result record.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Window geometry and field widths.
  localparam int WINDOW_MAX = 8;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SEQ_BITS   = 32;
  localparam int WS_W       = 4;
  localparam int TMO_W      = 16;
  localparam int INFL_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Reset values of the configuration registers.
  localparam logic [WS_W-1:0]  WINDOW_SIZE_RST   = WS_W'(3);
  localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = TMO_W'(50);

  // Opcodes on the input stream.
  localparam logic [1:0] OP_NEW  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_WINDOW_SIZE   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    CMD_NEW,
    CMD_ACK,
    CMD_TICK,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SEND   = 2'd1,
    KIND_RETX   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_OUTSIDE = 2'd2,
    STAT_DUP     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLIDE,
    S_WALK
  } back_state_e;

  // One classified request waiting for the back end.
  typedef struct packed {
    cmd_e                cmd;
    logic [SEQ_BITS-1:0] ack_num;
  } req_t;

  // One result record.
  typedef struct packed {
    kind_e               kind;
    logic [SEQ_BITS-1:0] seq_num;
    status_e             status;
    logic [SEQ_BITS-1:0] window_base;
    logic [INFL_W-1:0]   in_flight;
    logic                last;
  } res_t;

  // Map an opcode onto a command; the unused code is a no-op.
  function automatic cmd_e cmd_from_op(input logic [1:0] op);
    cmd_e c;
    unique case (op)
      OP_NEW:  c = CMD_NEW;
      OP_ACK:  c = CMD_ACK;
      OP_TICK: c = CMD_TICK;
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== design/selective_repeat_send_window_core.sv =====
// Path: a request passes the intake register, the request queue and the window
// engine; results leave through the engine's output register. An accepted ack retires
// its leading acked slots (up to 8) one per cycle, and a tick walks the window one slot
// per cycle unless a due result waits; the engine takes no queued request until done.
// Reset (asynchronous, active low) empties the window and loads window size 3
// and timeout 50; the engine is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// selective_repeat_send_window_core: sender window of a selective-repeat ARQ
// Intake register, request queue and window engine, with the APB register
// block for window size and retransmission timeout.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] ack_num
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] seq_num, [33:32] status,
                                      // [65:34] window_base, [69:66] in_flight
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srsw_pkg::*;

  logic [WS_W-1:0]  window_size_q;
  logic [TMO_W-1:0] timeout_ticks_q;
  logic             cfg_write;

  logic             fr_valid, q_ready, q_valid, q_pop;
  req_t             fr_req, q_req;
  logic             res_valid;
  res_t             res;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= WINDOW_SIZE_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WINDOW_SIZE:   window_size_q   <= pwdata[WS_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_SIZE:   prdata = 32'(window_size_q);
      REG_TIMEOUT_TICKS: prdata = 32'(timeout_ticks_q);
      default:           prdata = '0;
    endcase
  end

  // Intake and classification.
  srsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .ack_num_i   (s_axis_tdata),
    .req_valid_o (fr_valid),
    .req_ready_i (q_ready),
    .req_o       (fr_req)
  );

  // Request queue.
  srsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .ready_o (q_ready),
    .data_i  (fr_req),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_req)
  );

  // Window engine.
  srsw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (q_valid),
    .req_i           (q_req),
    .req_pop_o       (q_pop),
    .window_size_i   (window_size_q),
    .timeout_ticks_i (timeout_ticks_q),
    .res_valid_o     (res_valid),
    .res_ready_i     (m_axis_tready),
    .res_o           (res)
  );

  // Result packing.
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res.in_flight, res.window_base, res.status, res.seq_num};
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;

endmodule

// ===== design/srsw_front.sv =====
// ----------------------------------------------------------------------------
// srsw_front: request intake
// Takes requests from the input stream, classifies the opcode and holds the
// classified request in a register until the queue takes it.
// ----------------------------------------------------------------------------
module srsw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [srsw_pkg::SEQ_BITS-1:0]    ack_num_i,
  output logic                             req_valid_o,
  input  logic                             req_ready_i,
  output srsw_pkg::req_t                   req_o
);
  import srsw_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;

  // The holding register frees up when the queue takes its request.
  assign in_ready_o = !valid_q || req_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (req_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classified payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.cmd     <= cmd_from_op(op_i);
      req_q.ack_num <= ack_num_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ===== design/srsw_queue.sv =====
// ----------------------------------------------------------------------------
// srsw_queue: request queue
// Short first-in first-out queue that decouples intake from execution.
// ----------------------------------------------------------------------------
module srsw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  srsw_pkg::req_t data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output srsw_pkg::req_t data_o
);
  import srsw_pkg::*;

  req_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/srsw_back.sv =====
// ----------------------------------------------------------------------------
// srsw_back: window engine
// Holds the send window and executes queued requests: admission, ack marking
// with a slide of one slot per cycle, and a timer walk of one slot per cycle while results are not held up.
// ----------------------------------------------------------------------------
module srsw_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  srsw_pkg::req_t                  req_i,
  output logic                            req_pop_o,
  input  logic [srsw_pkg::WS_W-1:0]       window_size_i,
  input  logic [srsw_pkg::TMO_W-1:0]      timeout_ticks_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output srsw_pkg::res_t                  res_o
);
  import srsw_pkg::*;

  back_state_e               state_q, state_d;
  logic [SEQ_BITS-1:0]       base_q, base_d;
  logic [SLOT_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [WINDOW_MAX-1:0]     acked_q, acked_d;
  logic [WINDOW_MAX-1:0]     mask_q, mask_d;
  logic [CNT_W-1:0]          step_q, step_d;
  logic [TMO_W-1:0]          timer_q [WINDOW_MAX];

  logic                      timer_we;
  logic [SLOT_W-1:0]         timer_waddr;
  logic [TMO_W-1:0]          timer_wdata;

  logic                      out_valid_q;
  res_t                      res_q, res_d;
  logic                      out_free, emit;

  logic                      win_full;
  logic [SEQ_BITS-1:0]       ack_off;
  logic                      ack_in_win;
  logic [SLOT_W-1:0]         ack_idx;
  logic [WINDOW_MAX-1:0]     due_mask;
  logic [WINDOW_MAX-1:0]     due_rest;
  logic [SLOT_W-1:0]         walk_idx;

  assign out_free = !out_valid_q || res_ready_i;

  // Admission limit: the configured size saturates at the slot count.
  assign win_full = (32'(count_q) >= 32'(window_size_i)) ||
                    (count_q >= CNT_W'(WINDOW_MAX));

  // Ack position relative to the window base.
  assign ack_off    = req_i.ack_num - base_q;
  assign ack_in_win = (ack_off < SEQ_BITS'(count_q));
  assign ack_idx    = head_q + ack_off[SLOT_W-1:0];

  // Slots due for retransmission at this tick, in window order.
  always_comb begin
    for (int k = 0; k < WINDOW_MAX; k++) begin
      due_mask[k] = (CNT_W'(k) < count_q) && !acked_q[head_q + SLOT_W'(k)] &&
                    (timer_q[head_q + SLOT_W'(k)] <= TMO_W'(1));
    end
  end

  assign walk_idx = head_q + step_q[SLOT_W-1:0];
  assign due_rest = mask_q >> step_q;

  // Sequencer: next state, window update and result.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    head_d      = head_q;
    count_d     = count_q;
    acked_d     = acked_q;
    mask_d      = mask_q;
    step_d      = step_q;
    timer_we    = 1'b0;
    timer_waddr = '0;
    timer_wdata = timeout_ticks_i;
    req_pop_o   = 1'b0;
    emit        = 1'b0;
    res_d       = '0;
    res_d.kind   = KIND_STATUS;
    res_d.status = STAT_OK;
    res_d.last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (req_i.cmd)
            CMD_NEW: begin
              if (out_free) begin
                req_pop_o = 1'b1;
                emit      = 1'b1;
                if (win_full) begin
                  res_d.status = STAT_FULL;
                end else begin
                  acked_d[head_q + count_q[SLOT_W-1:0]] = 1'b0;
                  timer_we    = 1'b1;
                  timer_waddr = head_q + count_q[SLOT_W-1:0];
                  count_d       = count_q + 1'b1;
                  res_d.kind    = KIND_SEND;
                  res_d.seq_num = base_q + SEQ_BITS'(count_q);
                end
              end
            end
            CMD_ACK: begin
              if (!ack_in_win) begin
                if (out_free) begin
                  req_pop_o    = 1'b1;
                  emit         = 1'b1;
                  res_d.status = STAT_OUTSIDE;
                end
              end else if (acked_q[ack_idx]) begin
                if (out_free) begin
                  req_pop_o    = 1'b1;
                  emit         = 1'b1;
                  res_d.status = STAT_DUP;
                end
              end else begin
                req_pop_o        = 1'b1;
                acked_d[ack_idx] = 1'b1;
                state_d          = S_SLIDE;
              end
            end
            CMD_TICK: begin
              req_pop_o = 1'b1;
              mask_d    = due_mask;
              step_d    = '0;
              state_d   = S_WALK;
            end
            CMD_NOP: begin
              if (out_free) begin
                req_pop_o = 1'b1;
                emit      = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // Retire the leading acked slot each cycle, then report.
      S_SLIDE: begin
        if (count_q != '0 && acked_q[head_q]) begin
          acked_d[head_q] = 1'b0;
          head_d  = head_q + 1'b1;
          base_d  = base_q + 1'b1;
          count_d = count_q - 1'b1;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      // One slot per cycle unless a result stalls: reload and report due slots, count down unacked ones.
      S_WALK: begin
        if (step_q >= count_q) begin
          if (mask_q == '0) begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end else if (mask_q[step_q[SLOT_W-1:0]]) begin
          if (out_free) begin
            timer_we      = 1'b1;
            timer_waddr   = walk_idx;
            emit          = 1'b1;
            res_d.kind    = KIND_RETX;
            res_d.seq_num = base_q + SEQ_BITS'(step_q);
            res_d.last    = (due_rest[WINDOW_MAX-1:1] == '0);
            step_d        = step_q + 1'b1;
          end
        end else begin
          if (!acked_q[walk_idx]) begin
            timer_we    = 1'b1;
            timer_waddr = walk_idx;
            timer_wdata = timer_q[walk_idx] - 1'b1;
          end
          step_d = step_q + 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase

    res_d.window_base = base_d;
    res_d.in_flight   = INFL_W'(count_d);
  end

  // Window control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
      acked_q <= '0;
      mask_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      head_q  <= head_d;
      count_q <= count_d;
      acked_q <= acked_d;
      mask_q  <= mask_d;
      step_q  <= step_d;
    end
  end

  // Slot timers, one write per cycle.
  always_ff @(posedge clk_i) begin
    if (timer_we) begin
      timer_q[timer_waddr] <= timer_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // The window never holds more segments than there are slots.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_MAX))
    else $error("window count above slot count");

  // Between requests the oldest slot in flight is never an acked one.
  a_head_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q != '0) |-> !acked_q[head_q])
    else $error("window left resting on an acked slot");

  // The timer walk never passes the end of the window.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (step_q <= count_q))
    else $error("timer walk beyond window");

  // Retiring an acked head advances the base by one.
  a_slide_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLIDE && count_q != '0 && acked_q[head_q]) |=>
    (base_q == $past(base_q) + 1'b1))
    else $error("slide did not advance the base");

  // A retransmit result always carries an ok status.
  a_retx_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == KIND_RETX) |-> (res_q.status == STAT_OK))
    else $error("retransmit with error status");

endmodule

// ===== verif/tb_selective_repeat_send_window_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_send_window_core: self-checking bench for the send window
// Drives new-segment, ack, tick and no-op requests through the input stream.
// It writes window size and timeout over APB between phases and scores every
// result against a cycle-free model of the window kept inside the bench.
// ----------------------------------------------------------------------------
module tb_selective_repeat_send_window_core;
  import srsw_pkg::*;

  // Unused opcode; the block answers it with a plain status result.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles to let the engine settle after the last result, before an APB write or the verdict.
  localparam int SETTLE_CYCLES = 16;
  // Cycles with no transfer on any port before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int REQS_PER_PHASE = 54;

  // One row of the directed table: either an APB write or a request.
  typedef struct {
    bit                  is_cfg;
    logic                cfg_idx;
    logic [31:0]         cfg_val;
    logic [1:0]          op;
    logic [31:0]         ack;
    bit                  typed;
    res_t                exp_res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Window model: configuration, window position and per-slot state.
  logic [WS_W-1:0]     cfg_ws = WINDOW_SIZE_RST;
  logic [TMO_W-1:0]    cfg_tmo = TIMEOUT_TICKS_RST;
  logic [31:0]         win_base = '0;
  int unsigned         win_head = 0;
  int unsigned         win_count = 0;
  bit                  slot_acked [WINDOW_MAX];
  logic [TMO_W-1:0]    slot_timer_left [WINDOW_MAX];

  res_t                step_results [$];
  res_t                due_results [$];
  stim_row_t           stim_table [$];

  res_t                seen_res;
  res_t                want_res;
  int                  err_count = 0;
  int                  req_count = 0;
  int                  res_count = 0;
  int                  send_count = 0;
  int                  retx_count = 0;
  int                  full_count = 0;
  int                  bad_ack_count = 0;
  int                  cfg_count = 0;
  int                  stall_left = 0;
  int                  quiet_cycles = 0;
  bit                  idle_off = 1'b0;

  selective_repeat_send_window_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] ack_num
    .s_axis_tuser  (s_axis_tuser),   // [1:0] op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] seq_num, [33:32] status,
                                     // [65:34] window_base, [69:66] in_flight
    .m_axis_tuser  (m_axis_tuser),   // [1:0] kind
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result-side backpressure in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Record one result of the current request, with a snapshot of the window.
  task automatic add_result(input kind_e k, input logic [31:0] seq, input status_e st);
    res_t r;
    r.kind        = k;
    r.seq_num     = seq;
    r.status      = st;
    r.window_base = win_base;
    r.in_flight   = INFL_W'(win_count);
    r.last        = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  // Apply one request to the window model and collect its results.
  task automatic advance_window(input logic [1:0] op, input logic [31:0] ack);
    int unsigned lim;
    int unsigned idx;
    int unsigned n;
    logic [31:0] ack_dist;
    step_results.delete();
    lim = (cfg_ws > WINDOW_MAX) ? WINDOW_MAX : cfg_ws;
    case (op)
      OP_NEW: begin
        if (win_count >= lim) begin
          add_result(KIND_STATUS, '0, STAT_FULL);
        end else begin
          idx = (win_head + win_count) % WINDOW_MAX;
          slot_acked[idx]      = 1'b0;
          slot_timer_left[idx] = cfg_tmo;
          win_count++;
          add_result(KIND_SEND, win_base + 32'(win_count - 1), STAT_OK);
        end
      end
      OP_ACK: begin
        ack_dist = ack - win_base;
        if (ack_dist >= win_count) begin
          add_result(KIND_STATUS, '0, STAT_OUTSIDE);
        end else begin
          idx = (win_head + ack_dist) % WINDOW_MAX;
          if (slot_acked[idx]) begin
            add_result(KIND_STATUS, '0, STAT_DUP);
          end else begin
            slot_acked[idx] = 1'b1;
            // Slide over the whole leading run of acked slots.
            while (win_count > 0 && slot_acked[win_head]) begin
              slot_acked[win_head] = 1'b0;
              win_head  = (win_head + 1) % WINDOW_MAX;
              win_base  = win_base + 32'd1;
              win_count--;
            end
            add_result(KIND_STATUS, '0, STAT_OK);
          end
        end
      end
      OP_TICK: begin
        n = 0;
        for (int unsigned i = 0; i < win_count; i++) begin
          idx = (win_head + i) % WINDOW_MAX;
          if (!slot_acked[idx]) begin
            if (slot_timer_left[idx] <= 1) begin
              slot_timer_left[idx] = cfg_tmo;
              add_result(KIND_RETX, win_base + 32'(i), STAT_OK);
              n++;
            end else begin
              slot_timer_left[idx] = slot_timer_left[idx] - 1'b1;
            end
          end
        end
        if (n == 0) add_result(KIND_STATUS, '0, STAT_OK);
      end
      default: add_result(KIND_STATUS, '0, STAT_OK);
    endcase
  endtask

  // Send one request, then queue what the window model says must come back.
  task automatic issue_request(input logic [1:0] op, input logic [31:0] ack,
                               input bit typed, input res_t exp);
    int unsigned gap;
    res_t r;
    gap = 0;
    if (!idle_off && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ack;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_window(op, ack);
    if (typed) begin
      due_results.insert(due_results.size(), exp);
    end else begin
      foreach (step_results[i]) begin
        r      = step_results[i];
        r.last = (i == step_results.size() - 1);
        due_results.insert(due_results.size(), r);
      end
    end
    req_count++;
  endtask

  // Wait for outstanding results, write one register over APB and read it back.
  task automatic set_register(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] want;
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mask = (idx == REG_WINDOW_SIZE) ? 32'h0000_000F : 32'h0000_FFFF;
    want = val & mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= want | ($urandom & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // Write done; turn straight into the read-back setup cycle.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0h, actual %0h", idx, want, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_WINDOW_SIZE) cfg_ws = want[WS_W-1:0];
    else cfg_tmo = want[TMO_W-1:0];
    cfg_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      err_count++;
    end
  endtask

  // Directed table builders.
  task automatic row_item(input logic [1:0] op, input logic [31:0] ack);
    stim_row_t row;
    row        = '{default: '0};
    row.op     = op;
    row.ack    = ack;
    stim_table.insert(stim_table.size(), row);
  endtask

  task automatic row_typed(input logic [1:0] op, input logic [31:0] ack, input kind_e k,
                           input logic [31:0] seq, input status_e st,
                           input logic [31:0] base, input logic [3:0] infl);
    stim_row_t row;
    row                     = '{default: '0};
    row.op                  = op;
    row.ack                 = ack;
    row.typed               = 1'b1;
    row.exp_res.kind        = k;
    row.exp_res.seq_num     = seq;
    row.exp_res.status      = st;
    row.exp_res.window_base = base;
    row.exp_res.in_flight   = infl;
    row.exp_res.last        = 1'b1;
    stim_table.insert(stim_table.size(), row);
  endtask

  task automatic row_cfg(input logic idx, input logic [31:0] val);
    stim_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    stim_table.insert(stim_table.size(), row);
  endtask

  // Score every result that leaves the block against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res.kind        = kind_e'(m_axis_tuser);
      seen_res.seq_num     = m_axis_tdata[31:0];
      seen_res.status      = status_e'(m_axis_tdata[33:32]);
      seen_res.window_base = m_axis_tdata[65:34];
      seen_res.in_flight   = m_axis_tdata[69:66];
      seen_res.last        = m_axis_tlast;
      res_count++;
      if (seen_res.kind == KIND_SEND) send_count++;
      if (seen_res.kind == KIND_RETX) retx_count++;
      if (seen_res.status == STAT_FULL) full_count++;
      if (seen_res.status == STAT_OUTSIDE || seen_res.status == STAT_DUP) bad_ack_count++;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: kind %0d seq %0d status %0d",
               seen_res.kind, seen_res.seq_num, seen_res.status);
        err_count++;
      end else begin
        want_res = due_results[0];
        due_results.delete(0);
        compare_field("kind", 32'(want_res.kind), 32'(seen_res.kind));
        compare_field("seq_num", want_res.seq_num, seen_res.seq_num);
        compare_field("status", 32'(want_res.status), 32'(seen_res.status));
        compare_field("window_base", want_res.window_base, seen_res.window_base);
        compare_field("in_flight", 32'(want_res.in_flight), 32'(seen_res.in_flight));
        compare_field("last", 32'(want_res.last), 32'(seen_res.last));
      end
    end
  end

  // Hang detection: any transfer on any port restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb_selective_repeat_send_window_core: done, errors");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    int unsigned phase_ws [RANDOM_PHASES];
    int unsigned phase_tmo [RANDOM_PHASES];
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] ack;
    res_t        none;

    phase_ws  = '{8, 0, 1, 15, 5, 4};
    phase_tmo = '{2, 5, 0, 65535, 3, 1};
    none = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: window of 3, timeout 50.
    row_typed(OP_NEW, 32'h0, KIND_SEND, 32'd0, STAT_OK, 32'd0, 4'd1);
    row_item(OP_NEW, 32'hFFFF_FFFF);
    row_item(OP_NEW, 32'h0);
    row_typed(OP_NEW, 32'h0, KIND_STATUS, 32'd0, STAT_FULL, 32'd0, 4'd3);
    row_typed(OP_ACK, 32'hFFFF_FFFF, KIND_STATUS, 32'd0, STAT_OUTSIDE, 32'd0, 4'd3);
    row_item(OP_ACK, 32'd1);
    row_typed(OP_ACK, 32'd1, KIND_STATUS, 32'd0, STAT_DUP, 32'd0, 4'd3);
    row_item(OP_ACK, 32'd0);
    row_item(OP_TICK, 32'h0);
    row_typed(OP_UNUSED, 32'hA5A5_5A5A, KIND_STATUS, 32'd0, STAT_OK, 32'd2, 4'd1);
    row_typed(OP_ACK, 32'd3, KIND_STATUS, 32'd0, STAT_OUTSIDE, 32'd2, 4'd1);
    row_item(OP_ACK, 32'd2);
    row_typed(OP_ACK, 32'd3, KIND_STATUS, 32'd0, STAT_OUTSIDE, 32'd3, 4'd0);
    // Oversized window saturates to eight slots; timeout of one tick.
    row_cfg(REG_WINDOW_SIZE, 32'd15);
    row_cfg(REG_TIMEOUT_TICKS, 32'd1);
    for (int i = 0; i < WINDOW_MAX; i++) row_item(OP_NEW, 32'h0);
    row_typed(OP_NEW, 32'h0, KIND_STATUS, 32'd0, STAT_FULL, 32'd3, 4'd8);
    row_item(OP_TICK, 32'h0);
    row_item(OP_ACK, 32'd10);
    row_item(OP_ACK, 32'd3);
    // Zero timeout expires every unacked slot; zero window admits nothing.
    row_cfg(REG_TIMEOUT_TICKS, 32'd0);
    row_item(OP_TICK, 32'h0);
    row_cfg(REG_WINDOW_SIZE, 32'd0);
    row_typed(OP_NEW, 32'h0, KIND_STATUS, 32'd0, STAT_FULL, 32'd4, 4'd7);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) set_register(stim_table[i].cfg_idx, stim_table[i].cfg_val);
      else issue_request(stim_table[i].op, stim_table[i].ack, stim_table[i].typed,
                         stim_table[i].exp_res);
    end

    // Random phases: mostly well-formed traffic, some stray and stale acks.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_register(REG_WINDOW_SIZE, phase_ws[p]);
      set_register(REG_TIMEOUT_TICKS, phase_tmo[p]);
      if (p == RANDOM_PHASES - 1) idle_off = 1'b1;
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        ack  = $urandom;
        if (pick < 35 || (pick < 65 && win_count == 0)) begin
          op = OP_NEW;
        end else if (pick < 65) begin
          op  = OP_ACK;
          ack = win_base + (($urandom_range(0, 2) == 0) ? 32'd0 :
                            32'($urandom_range(0, win_count - 1)));
        end else if (pick < 85) begin
          op = OP_TICK;
        end else if (pick < 92) begin
          op = OP_ACK;
        end else if (pick < 96) begin
          op  = OP_ACK;
          ack = ($urandom_range(0, 1) == 0) ? win_base - 32'($urandom_range(1, 4)) :
                                              win_base + 32'(win_count);
        end else begin
          op = OP_UNUSED;
        end
        issue_request(op, ack, 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      err_count++;
    end

    $display("Run covered %0d requests and %0d results over %0d register writes.",
             req_count, res_count, cfg_count);
    $display("Seen: %0d sends, %0d retransmits, %0d full rejects, %0d bad or repeated acks.",
             send_count, retx_count, full_count, bad_ack_count);
    if (err_count == 0) begin
      $display("tb_selective_repeat_send_window_core: done, clean");
    end else begin
      $display("tb_selective_repeat_send_window_core: done, errors");
    end
    $finish;
  end

endmodule
